@@ hdl/tpc_pkg.sv @@
// tpc_pkg: shared types and constants of the triangle plane clipper
// depends on nothing; imported by every module of the block

package tpc_pkg;

    localparam int NUM_VERT     = 3;
    localparam int COORD_W      = 32;
    localparam int MAG_W        = 64;
    localparam int PROD_W       = 64;
    localparam int DIV_STEPS    = 31;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_ADDR_W   = 4;
    localparam int OFFSET_SHIFT = 16;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_PLANE_A      = 2'd0,
        REG_PLANE_B      = 2'd1,
        REG_PLANE_C      = 2'd2,
        REG_PLANE_OFFSET = 2'd3
    } reg_idx_t;

    localparam logic [COORD_W-1:0] PLANE_A_RST      = 32'sd0;
    localparam logic [COORD_W-1:0] PLANE_B_RST      = 32'sd0;
    localparam logic [COORD_W-1:0] PLANE_C_RST      = 32'sd65536;
    localparam logic [COORD_W-1:0] PLANE_OFFSET_RST = 32'sd0;

    typedef logic [COORD_W-1:0] coord_t;
    typedef coord_t [2:0] vec3_t;
    typedef vec3_t [NUM_VERT-1:0] tri_t;

    typedef struct packed {
        coord_t plane_a;
        coord_t plane_b;
        coord_t plane_c;
        coord_t plane_offset;
    } plane_t;

    typedef struct packed {
        coord_t v0_x;
        coord_t v0_y;
        coord_t v0_z;
        coord_t v1_x;
        coord_t v1_y;
        coord_t v1_z;
        coord_t v2_x;
        coord_t v2_y;
        coord_t v2_z;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] lone_index;
        logic [1:0] inside_count;
        coord_t     left_x;
        coord_t     left_y;
        coord_t     left_z;
        coord_t     right_x;
        coord_t     right_y;
        coord_t     right_z;
    } out_beat_t;

    // classified triangle handed from the front to the back
    typedef struct packed {
        logic [1:0]       lone_index;
        logic [1:0]       inside_count;
        logic             cut;
        vec3_t            lone_v;
        vec3_t            nxt_v;
        vec3_t            far_v;
        logic [MAG_W-1:0] lone_mag;
        logic [MAG_W-1:0] nxt_mag;
        logic [MAG_W-1:0] far_mag;
    } job_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ hdl/tpc_front.sv @@
// tpc_front: plane distance of each vertex and classification of the triangle
// depends on tpc_pkg; feeds tpc_queue

module tpc_front
    import tpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  plane_t   plane,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_beat_t in_data,
    input  q_stat_t  q_stat,
    output logic     push,
    output job_t     push_job
);

    logic f1_valid_reg, f1_valid_next;
    logic f2_valid_reg, f2_valid_next;
    logic f3_valid_reg, f3_valid_next;
    logic adv;

    tri_t in_tri;
    tri_t f1_tri_reg, f2_tri_reg, f3_tri_reg;
    logic signed [PROD_W-1:0] f1_prod_reg [NUM_VERT][3];
    logic signed [PROD_W-1:0] prod_next [NUM_VERT][3];
    logic signed [COORD_W+OFFSET_SHIFT-1:0] f1_doff_reg;
    logic signed [PROD_W:0] f2_sa_reg [NUM_VERT];
    logic signed [PROD_W:0] f2_sb_reg [NUM_VERT];
    logic f3_neg_reg [NUM_VERT];
    logic [MAG_W-1:0] f3_mag_reg [NUM_VERT];
    logic signed [PROD_W+1:0] sum_next [NUM_VERT];

    logic [NUM_VERT-1:0] pos;
    logic [1:0] in_count;
    logic [1:0] lone;
    logic [1:0] nxt;
    logic [1:0] far;
    logic       found;
    logic       cut;

    // whole front moves together; holds when the queue is full and the last stage holds a triangle
    assign adv      = !(f3_valid_reg && q_stat.full);
    assign in_ready = adv;
    assign push     = f3_valid_reg && !q_stat.full;

    assign in_tri[0] = '{in_data.v0_z, in_data.v0_y, in_data.v0_x};
    assign in_tri[1] = '{in_data.v1_z, in_data.v1_y, in_data.v1_x};
    assign in_tri[2] = '{in_data.v2_z, in_data.v2_y, in_data.v2_x};

    assign f1_valid_next = in_valid;
    assign f2_valid_next = f1_valid_reg;
    assign f3_valid_next = f2_valid_reg;

    // products of the normal with each vertex
    always_comb
    begin
        for (int i = 0; i < NUM_VERT; i++)
        begin
            prod_next[i][0] = $signed(plane.plane_a) * $signed(in_tri[i][0]);
            prod_next[i][1] = $signed(plane.plane_b) * $signed(in_tri[i][1]);
            prod_next[i][2] = $signed(plane.plane_c) * $signed(in_tri[i][2]);
        end
    end

    // final sum, exact in 66 bits
    always_comb
    begin
        for (int i = 0; i < NUM_VERT; i++)
        begin
            sum_next[i] = $signed({f2_sa_reg[i][PROD_W], f2_sa_reg[i]})
                          + $signed({f2_sb_reg[i][PROD_W], f2_sb_reg[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
            f3_valid_reg <= f3_valid_next;
        end
    end

    // distance pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_tri_reg  <= in_tri;
            f1_doff_reg <= $signed({plane.plane_offset, {OFFSET_SHIFT{1'b0}}});
            f2_tri_reg  <= f1_tri_reg;
            f3_tri_reg  <= f2_tri_reg;
            for (int i = 0; i < NUM_VERT; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    f1_prod_reg[i][j] <= prod_next[i][j];
                end
                f2_sa_reg[i] <= (PROD_W+1)'(f1_prod_reg[i][0]) + (PROD_W+1)'(f1_prod_reg[i][1]);
                f2_sb_reg[i] <= (PROD_W+1)'(f1_prod_reg[i][2]) + (PROD_W+1)'(f1_doff_reg);
                f3_neg_reg[i] <= sum_next[i][PROD_W+1];
                f3_mag_reg[i] <= sum_next[i][PROD_W+1] ? MAG_W'(-sum_next[i])
                                                       : MAG_W'(sum_next[i]);
            end
        end
    end

    // inside count and lone vertex
    always_comb
    begin
        for (int i = 0; i < NUM_VERT; i++)
        begin
            pos[i] = !f3_neg_reg[i] && (f3_mag_reg[i] != '0);
        end
        in_count = 2'($countones(pos));
        cut      = (in_count == 2'd1) || (in_count == 2'd2);
        lone     = 2'd0;
        found    = 1'b0;
        for (int i = 0; i < NUM_VERT; i++)
        begin
            if (!found && cut)
            begin
                if ((in_count == 2'd1) ? !f3_neg_reg[i]
                                       : (f3_neg_reg[i] || f3_mag_reg[i] == '0))
                begin
                    lone  = 2'(i);
                    found = 1'b1;
                end
            end
        end
        nxt = (lone == 2'd2) ? 2'd0 : lone + 2'd1;
        far = (lone == 2'd0) ? 2'd2 : lone - 2'd1;
    end

    // job for the back
    always_comb
    begin
        push_job.lone_index   = lone;
        push_job.inside_count = in_count;
        push_job.cut          = cut;
        push_job.lone_v       = f3_tri_reg[lone];
        push_job.nxt_v        = f3_tri_reg[nxt];
        push_job.far_v        = f3_tri_reg[far];
        push_job.lone_mag     = f3_mag_reg[lone];
        push_job.nxt_mag      = f3_mag_reg[nxt];
        push_job.far_mag      = f3_mag_reg[far];
    end

endmodule

@@ hdl/tpc_queue.sv @@
// tpc_queue: short queue of classified triangles between front and back
// depends on tpc_pkg

module tpc_queue
    import tpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    pop_job,
    output q_stat_t q_stat
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_job      = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("pop from empty queue");
    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");
`endif

endmodule

@@ hdl/tpc_back.sv @@
// tpc_back: edge parameter division and cut point arithmetic
// depends on tpc_pkg; takes jobs from tpc_queue

module tpc_back
    import tpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_stat_t   q_stat,
    output logic      pop,
    input  job_t      pop_job,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    typedef struct packed {
        logic [MAG_W-1:0]     rem;
        logic [MAG_W-1:0]     div;
        logic [DIV_STEPS-1:0] quo;
        logic                 ok;
        logic                 full;
    } div_t;

    function automatic div_t div_step(input div_t d);
        div_t       r;
        logic       top;
        logic [MAG_W-1:0] sh;
        logic       bit_q;
        r     = d;
        top   = d.rem[MAG_W-1];
        sh    = {d.rem[MAG_W-2:0], 1'b0};
        bit_q = top || (sh >= d.div);
        r.rem = bit_q ? sh - d.div : sh;
        r.quo = {d.quo[DIV_STEPS-2:0], bit_q};
        return r;
    endfunction

    function automatic div_t div_setup(input logic [MAG_W-1:0] ma_in,
                                       input logic [MAG_W-1:0] mb_in);
        div_t           r;
        logic [MAG_W:0] wide;
        logic [MAG_W-1:0] ma;
        logic [MAG_W-1:0] mb;
        wide   = {1'b0, ma_in} + {1'b0, mb_in};
        ma     = wide[MAG_W] ? (ma_in >> 1) : ma_in;
        mb     = wide[MAG_W] ? (mb_in >> 1) : mb_in;
        r.div  = ma + mb;
        r.rem  = ma;
        r.quo  = '0;
        r.ok   = (r.div != '0);
        r.full = (ma == r.div);
        return r;
    endfunction

    localparam int MUL_W = COORD_W + 1 + COORD_W;

    logic en;
    logic out_valid_reg;
    out_beat_t out_reg;

    logic sv_reg [DIV_STEPS+1];
    job_t sjob_reg [DIV_STEPS+1];
    div_t sdiv_reg [DIV_STEPS+1][2];

    logic mv_reg;
    job_t mjob_reg;
    logic mok_reg [2];
    logic [MUL_W-1:0] mprod_reg [2][3];
    logic mneg_reg [2][3];

    logic [COORD_W:0] t_next [2];
    logic signed [COORD_W:0] diff_next [2][3];
    logic [COORD_W:0] dmag_next [2][3];
    coord_t pt_next [2][3];
    vec3_t far_end [2];

    // whole back advances unless the output beat is stuck
    assign en        = !out_valid_reg || out_ready;
    assign pop       = en && !q_stat.empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // edge parameter and coordinate deltas
    always_comb
    begin
        far_end[0] = sjob_reg[DIV_STEPS].nxt_v;
        far_end[1] = sjob_reg[DIV_STEPS].far_v;
        for (int e = 0; e < 2; e++)
        begin
            t_next[e] = sdiv_reg[DIV_STEPS][e].full ? (COORD_W+1)'(32'h8000_0000)
                        : (COORD_W+1)'(sdiv_reg[DIV_STEPS][e].quo);
            for (int j = 0; j < 3; j++)
            begin
                diff_next[e][j] = $signed({far_end[e][j][COORD_W-1], far_end[e][j]})
                    - $signed({sjob_reg[DIV_STEPS].lone_v[j][COORD_W-1],
                               sjob_reg[DIV_STEPS].lone_v[j]});
                dmag_next[e][j] = diff_next[e][j][COORD_W] ? (COORD_W+1)'(-diff_next[e][j])
                                                           : (COORD_W+1)'(diff_next[e][j]);
            end
        end
    end

    // offset, add and saturate; points are zero when the triangle is not cut
    always_comb
    begin
        for (int e = 0; e < 2; e++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                logic [COORD_W+1:0] off;
                logic signed [COORD_W+3:0] res;
                off = mprod_reg[e][j][MUL_W-1:DIV_STEPS];
                res = $signed({{4{mjob_reg.lone_v[j][COORD_W-1]}}, mjob_reg.lone_v[j]});
                if (mok_reg[e])
                begin
                    res = mneg_reg[e][j] ? res - $signed({2'b00, off})
                                         : res + $signed({2'b00, off});
                end
                if (res > $signed((COORD_W+4)'(32'h7FFF_FFFF)))
                begin
                    pt_next[e][j] = 32'h7FFF_FFFF;
                end
                else if (res < -$signed((COORD_W+4)'(33'h1_0000_0000 >> 1)))
                begin
                    pt_next[e][j] = 32'h8000_0000;
                end
                else
                begin
                    pt_next[e][j] = res[COORD_W-1:0];
                end
                if (!mjob_reg.cut)
                begin
                    pt_next[e][j] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                sv_reg[k] <= 1'b0;
            end
            mv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= !q_stat.empty;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
            mv_reg        <= sv_reg[DIV_STEPS];
            out_valid_reg <= mv_reg;
        end
    end

    // division setup, then division stages of one quotient bit each
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sjob_reg[0]    <= pop_job;
            sdiv_reg[0][0] <= div_setup(pop_job.lone_mag, pop_job.nxt_mag);
            sdiv_reg[0][1] <= div_setup(pop_job.lone_mag, pop_job.far_mag);
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                sjob_reg[k]    <= sjob_reg[k-1];
                sdiv_reg[k][0] <= div_step(sdiv_reg[k-1][0]);
                sdiv_reg[k][1] <= div_step(sdiv_reg[k-1][1]);
            end
        end
    end

    // multiply stage and output beat
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mjob_reg <= sjob_reg[DIV_STEPS];
            for (int e = 0; e < 2; e++)
            begin
                mok_reg[e] <= sdiv_reg[DIV_STEPS][e].ok;
                for (int j = 0; j < 3; j++)
                begin
                    mprod_reg[e][j] <= MUL_W'(dmag_next[e][j]) * MUL_W'(t_next[e]);
                    mneg_reg[e][j]  <= diff_next[e][j][COORD_W];
                end
            end
            out_reg.lone_index   <= mjob_reg.lone_index;
            out_reg.inside_count <= mjob_reg.inside_count;
            out_reg.left_x       <= pt_next[0][0];
            out_reg.left_y       <= pt_next[0][1];
            out_reg.left_z       <= pt_next[0][2];
            out_reg.right_x      <= pt_next[1][0];
            out_reg.right_y      <= pt_next[1][1];
            out_reg.right_z      <= pt_next[1][2];
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");
    a_no_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && en && !mjob_reg.cut) |=> out_data.lone_index == 2'd0)
        else $error("lone index nonzero without a cut");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sv_reg[DIV_STEPS] && sdiv_reg[DIV_STEPS][0].ok && !sdiv_reg[DIV_STEPS][0].full) |->
        sdiv_reg[DIV_STEPS][0].rem < sdiv_reg[DIV_STEPS][0].div)
        else $error("division remainder not below divisor");
`endif

endmodule

@@ hdl/triangle_plane_clip.sv @@
// triangle_plane_clip: top level, plane registers and front/queue/back wiring
// depends on tpc_pkg, tpc_front, tpc_queue, tpc_back
//
//  channel   dir  handshake             payload
//  in        in   in_valid / in_ready   in_data  (three vertices, Q16.16)
//  out       out  out_valid / out_ready out_data (lone, count, two cut points)
//  config    in   psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// one triangle per cycle sustained while out_ready holds; a triangle passes the
// front stages, the queue, then the back's 31-step pipelined quotient per edge
// reset clears all valid state and loads the plane registers to z = 0
// a stalled output freezes the back, then fills the 4-entry queue, then drops in_ready

module triangle_plane_clip
    import tpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [COORD_W-1:0]    pwdata,
    output logic [COORD_W-1:0]    prdata,
    output logic                  pready
);

    plane_t   plane_reg, plane_next;
    reg_idx_t widx;
    logic     wr_en;
    logic     push;
    logic     pop;
    job_t     push_job;
    job_t     pop_job;
    q_stat_t  q_stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    // register write decode
    always_comb
    begin
        plane_next = plane_reg;
        if (wr_en)
        begin
            unique case (widx)
                REG_PLANE_A:      plane_next.plane_a      = pwdata;
                REG_PLANE_B:      plane_next.plane_b      = pwdata;
                REG_PLANE_C:      plane_next.plane_c      = pwdata;
                REG_PLANE_OFFSET: plane_next.plane_offset = pwdata;
                default:          plane_next = plane_reg;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        unique case (widx)
            REG_PLANE_A:      prdata = plane_reg.plane_a;
            REG_PLANE_B:      prdata = plane_reg.plane_b;
            REG_PLANE_C:      prdata = plane_reg.plane_c;
            REG_PLANE_OFFSET: prdata = plane_reg.plane_offset;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.plane_a      <= PLANE_A_RST;
            plane_reg.plane_b      <= PLANE_B_RST;
            plane_reg.plane_c      <= PLANE_C_RST;
            plane_reg.plane_offset <= PLANE_OFFSET_RST;
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

    // classification front
    tpc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .plane    (plane_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    // job queue
    tpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    // cut point back
    tpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop       (pop),
        .pop_job   (pop_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for triangle_plane_clip
// depends on tpc_pkg and the triangle_plane_clip rtl; predicts each cut point in-bench

import tpc_pkg::*;

// expected beats and mismatch tally
class clip_scoreboard;
    out_beat_t pending[$];
    int        errors;
    int        checked;
    logic signed [63:0] na, nb, nc, nd;

    function new();
        errors  = 0;
        checked = 0;
        na = 0;
        nb = 0;
        nc = 65536;
        nd = 0;
    endfunction

    function void set_plane(reg_idx_t idx, logic [31:0] val);
        case (idx)
            REG_PLANE_A:      na = $signed(val);
            REG_PLANE_B:      nb = $signed(val);
            REG_PLANE_C:      nc = $signed(val);
            REG_PLANE_OFFSET: nd = $signed(val);
            default: ;
        endcase
    endfunction

    // exact signed distance as sign and magnitude
    function void vertex_dist(logic signed [63:0] x, logic signed [63:0] y,
                              logic signed [63:0] z, output bit neg,
                              output logic [63:0] mag);
        logic [64:0] p;
        logic [64:0] n;
        logic signed [63:0] terms[4];
        p = 0;
        n = 0;
        terms[0] = na * x;
        terms[1] = nb * y;
        terms[2] = nc * z;
        terms[3] = nd * 65536;
        foreach (terms[k])
        begin
            if (terms[k] < 0)
                n = n + (65'd0 - {terms[k][63], terms[k]});
            else
                p = p + {1'b0, terms[k]};
        end
        // 64-bit wraparound matches exact magnitude
        if (n > p)
        begin
            neg = 1;
            mag = 64'(n - p);
        end
        else
        begin
            neg = 0;
            mag = 64'(p - n);
        end
    endfunction

    // fraction of the edge in q1.31; ok low on zero divisor
    function void edge_frac(logic [63:0] ma, logic [63:0] mb, output bit ok,
                            output logic [31:0] t);
        logic [63:0] s;
        logic [63:0] r;
        bit          top;
        t = 0;
        if (ma + mb < ma)
        begin
            ma = ma >> 1;
            mb = mb >> 1;
        end
        s  = ma + mb;
        ok = (s != 0);
        if (!ok)
            return;
        if (ma == s)
        begin
            t = 32'h8000_0000;
            return;
        end
        r = ma;
        for (int i = 0; i < 31; i++)
        begin
            top = r[63];
            r   = r << 1;
            t   = t << 1;
            if (top || r >= s)
            begin
                r    = r - s;
                t[0] = 1'b1;
            end
        end
    endfunction

    function logic [31:0] cut_coord(logic signed [31:0] a, logic signed [31:0] b,
                                    bit ok, logic [31:0] t);
        logic signed [33:0] diff;
        logic [33:0]        dmag;
        logic [65:0]        prod;
        logic signed [34:0] res;
        diff = 34'(b) - 34'(a);
        res  = 35'(a);
        if (ok)
        begin
            dmag = diff < 0 ? -diff : diff;
            prod = dmag * t;
            prod = prod >> 31;
            if (diff < 0)
                res = res - 35'(prod);
            else
                res = res + 35'(prod);
        end
        if (res > 35'sd2147483647)
            res = 35'sd2147483647;
        if (res < -35'sd2147483648)
            res = -35'sd2147483648;
        return res[31:0];
    endfunction

    // note an accepted triangle and queue its expected result
    function void note_triangle(in_beat_t trg);
        logic signed [31:0] v[3][3];
        bit          neg[3];
        logic [63:0] mag[3];
        int          in_count, lone, o;
        bit          ok;
        logic [31:0] t;
        logic [31:0] pt[3];
        out_beat_t   e;
        v[0] = '{trg.v0_x, trg.v0_y, trg.v0_z};
        v[1] = '{trg.v1_x, trg.v1_y, trg.v1_z};
        v[2] = '{trg.v2_x, trg.v2_y, trg.v2_z};
        in_count = 0;
        lone     = 0;
        e        = '0;
        for (int i = 0; i < 3; i++)
        begin
            vertex_dist(v[i][0], v[i][1], v[i][2], neg[i], mag[i]);
            if (!neg[i] && mag[i] != 0)
                in_count++;
        end
        if (in_count == 1 || in_count == 2)
        begin
            for (int i = 2; i >= 0; i--)
                if ((in_count == 1) ? !neg[i] : (neg[i] || mag[i] == 0))
                    lone = i;
            for (int k = 1; k <= 2; k++)
            begin
                o = (lone + k) % 3;
                edge_frac(mag[lone], mag[o], ok, t);
                for (int j = 0; j < 3; j++)
                    pt[j] = cut_coord(v[lone][j], v[o][j], ok, t);
                if (k == 1)
                    {e.left_x, e.left_y, e.left_z} = {pt[0], pt[1], pt[2]};
                else
                    {e.right_x, e.right_y, e.right_z} = {pt[0], pt[1], pt[2]};
            end
        end
        e.lone_index   = 2'(lone);
        e.inside_count = 2'(in_count);
        pending.push_back(e);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endfunction

    // compare one output beat with the oldest expectation
    function void check_result(out_beat_t got);
        out_beat_t w;
        if (pending.size() == 0)
        begin
            errors++;
            $display("unexpected output beat %h", got);
            return;
        end
        w = pending.pop_front();
        checked++;
        if (got.lone_index !== w.lone_index)
            report("lone_index", got.lone_index, w.lone_index);
        if (got.inside_count !== w.inside_count)
            report("inside_count", got.inside_count, w.inside_count);
        if (got.left_x !== w.left_x)   report("left_x", got.left_x, w.left_x);
        if (got.left_y !== w.left_y)   report("left_y", got.left_y, w.left_y);
        if (got.left_z !== w.left_z)   report("left_z", got.left_z, w.left_z);
        if (got.right_x !== w.right_x) report("right_x", got.right_x, w.right_x);
        if (got.right_y !== w.right_y) report("right_y", got.right_y, w.right_y);
        if (got.right_z !== w.right_z) report("right_z", got.right_z, w.right_z);
    endfunction
endclass

module testbench;
    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_beat_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_beat_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [COORD_W-1:0]    pwdata;
    logic [COORD_W-1:0]    prdata;
    logic                  pready;

    clip_scoreboard sb;
    bit             calm;
    int             cycles;
    int             sent;

    triangle_plane_clip uut (.*);

    // clock
    initial clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // output side: check beats, stall in random bursts
    initial
    begin
        int stall;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (stall > 0)
            begin
                stall--;
                out_ready <= 0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 9) - 1;
                out_ready <= 0;
            end
            else
                out_ready <= 1;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        sb.set_plane(idx, val);
    endtask

    task automatic set_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] d);
        write_reg(REG_PLANE_A, a);
        write_reg(REG_PLANE_B, b);
        write_reg(REG_PLANE_C, c);
        write_reg(REG_PLANE_OFFSET, d);
    endtask

    // send one triangle, optional gap burst first
    task automatic send_triangle(in_beat_t trg);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= trg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_triangle(trg);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
        endcase
    endfunction

    function automatic in_beat_t rand_triangle();
        in_beat_t t;
        int       m;
        m = $urandom_range(0, 9);
        m = m < 3 ? 0 : (m < 7 ? 1 : (m < 9 ? 3 : 2));
        t.v0_x = rand_coord(m);
        t.v0_y = rand_coord(m);
        t.v0_z = rand_coord(m);
        t.v1_x = rand_coord(m);
        t.v1_y = rand_coord(m);
        t.v1_z = rand_coord(m);
        t.v2_x = rand_coord(m);
        t.v2_y = rand_coord(m);
        t.v2_z = rand_coord(m);
        if ($urandom_range(0, 15) == 0)
            t.v1_z = 32'h8000_0000;
        return t;
    endfunction

    function automatic in_beat_t tri_z(int z0, int z1, int z2);
        in_beat_t t;
        t      = '0;
        t.v0_x = 32'h0001_0000;
        t.v1_y = 32'h0002_0000;
        t.v2_x = 32'hfffe_0000;
        t.v0_z = z0 << 16;
        t.v1_z = z1 << 16;
        t.v2_z = z2 << 16;
        return t;
    endfunction

    initial
    begin
        int zs[$];
        sb       = new();
        calm     = 0;
        cycles   = 0;
        sent     = 0;
        rst_n    = 0;
        in_valid = 0;
        in_data  = '0;
        psel     = 0;
        penable  = 0;
        pwrite   = 0;
        paddr    = '0;
        pwdata   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every inside count, each lone position, touching vertices
        zs = '{1,-1,-1, -1,1,-1, -1,-1,1, -1,1,1, 1,-1,1, 1,1,-1,
               0,0,0, 1,1,1, -1,-1,-1, 0,1,-1, 0,-1,-1, 1,0,0, 0,0,1};
        for (int i = 0; i < zs.size(); i += 3)
            send_triangle(tri_z(zs[i], zs[i+1], zs[i+2]));
        send_triangle('0);
        send_triangle({9{32'h7fff_ffff}});
        send_triangle({9{32'h8000_0000}});
        send_triangle({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                       32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                       32'h0, 32'h0, 32'h7fff_ffff});

        // hold off until the pipe is empty
        drain();

        // random phases over several planes, extremes included
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_plane(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
                1: set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                             32'h8000_0000);
                2: set_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h7fff_ffff);
                3: set_plane(32'h0, 32'h0, 32'h0, 32'h0);
                default: set_plane($urandom(), $urandom(), $urandom(), $urandom());
            endcase
            if (ph == 6)
                calm = 1;
            for (int n = 0; n < 150; n++)
                send_triangle(ph == 3 ? tri_z(0, 1, -1) : rand_triangle());
            drain();
        end

        $display("run covered %0d triangles, %0d results checked over 8 plane settings",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/tpc_pkg.sv
hdl/tpc_front.sv
hdl/tpc_queue.sv
hdl/tpc_back.sv
hdl/triangle_plane_clip.sv
tb/testbench.sv
